>>> design/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Shared widths and types for the point-in-triangle test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pit_pkg;

   localparam int COORD_W    = 16;
   localparam int NUM_COORDS = 12;
   localparam int REQ_DATA_W = ((NUM_COORDS * COORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = 8;

   localparam int DIFF_W = COORD_W + 1;
   localparam int MUL1_W = 2 * DIFF_W;
   localparam int DOT_W  = MUL1_W + 2;

   // 2nd-level products are split into halves
   localparam int LO_W   = DOT_W / 2;
   localparam int HI_W   = DOT_W - LO_W;
   localparam int LL_W   = 2 * (LO_W + 1);
   localparam int LH_W   = LO_W + 1 + HI_W;
   localparam int HH_W   = 2 * HI_W;
   localparam int PROD_W = 2 * DOT_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int REST_W = PROD_W + 3;

   localparam int NUM_STAGES = 7;

   // coordinate order: v0 xyz, v1 xyz, v2 xyz, point xyz
   localparam int V0 = 0;
   localparam int V1 = 3;
   localparam int V2 = 6;
   localparam int PT = 9;

   typedef logic [NUM_COORDS-1:0][COORD_W-1:0] coord_set_type;

   typedef struct packed {
      logic signed [DOT_W-1:0] d00;
      logic signed [DOT_W-1:0] d01;
      logic signed [DOT_W-1:0] d02;
      logic signed [DOT_W-1:0] d11;
      logic signed [DOT_W-1:0] d12;
   } dot_set_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] den_a;
      logic signed [PROD_W-1:0] den_b;
      logic signed [PROD_W-1:0] nu_a;
      logic signed [PROD_W-1:0] nu_b;
      logic signed [PROD_W-1:0] nv_a;
      logic signed [PROD_W-1:0] nv_b;
   } prod_set_type;

   typedef struct packed {
      logic inside_res;
      logic degenerate;
   } result_type;

endpackage

`default_nettype wire

>>> design/pit_dot_unit.sv
// ----------------------------------------------------------------------------
// pit_dot_unit
// Three stages: edge vectors, per-component products, five dot products.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_dot_unit (
   input  wire logic                  clock,
   input  wire logic [2:0]            en,
   input  wire pit_pkg::coord_set_type coords,
   output pit_pkg::dot_set_type       dots
);

   logic signed [pit_pkg::DIFF_W-1:0] e0_ff [3];
   logic signed [pit_pkg::DIFF_W-1:0] e1_ff [3];
   logic signed [pit_pkg::DIFF_W-1:0] pv_ff [3];
   logic signed [pit_pkg::DIFF_W-1:0] e0_in [3];
   logic signed [pit_pkg::DIFF_W-1:0] e1_in [3];
   logic signed [pit_pkg::DIFF_W-1:0] pv_in [3];

   logic signed [pit_pkg::MUL1_W-1:0] m00_ff [3];
   logic signed [pit_pkg::MUL1_W-1:0] m01_ff [3];
   logic signed [pit_pkg::MUL1_W-1:0] m02_ff [3];
   logic signed [pit_pkg::MUL1_W-1:0] m11_ff [3];
   logic signed [pit_pkg::MUL1_W-1:0] m12_ff [3];

   pit_pkg::dot_set_type dots_ff;
   pit_pkg::dot_set_type dots_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e0_in[i] = pit_pkg::DIFF_W'($signed(coords[pit_pkg::V2 + i]))
                  - pit_pkg::DIFF_W'($signed(coords[pit_pkg::V0 + i]));
         e1_in[i] = pit_pkg::DIFF_W'($signed(coords[pit_pkg::V1 + i]))
                  - pit_pkg::DIFF_W'($signed(coords[pit_pkg::V0 + i]));
         pv_in[i] = pit_pkg::DIFF_W'($signed(coords[pit_pkg::PT + i]))
                  - pit_pkg::DIFF_W'($signed(coords[pit_pkg::V0 + i]));
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e0_ff <= e0_in;
         e1_ff <= e1_in;
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            m00_ff[i] <= e0_ff[i] * e0_ff[i];
            m01_ff[i] <= e0_ff[i] * e1_ff[i];
            m02_ff[i] <= e0_ff[i] * pv_ff[i];
            m11_ff[i] <= e1_ff[i] * e1_ff[i];
            m12_ff[i] <= e1_ff[i] * pv_ff[i];
         end
      end
   end

   always_comb begin
      dots_in.d00 = pit_pkg::DOT_W'(m00_ff[0]) + pit_pkg::DOT_W'(m00_ff[1])
                  + pit_pkg::DOT_W'(m00_ff[2]);
      dots_in.d01 = pit_pkg::DOT_W'(m01_ff[0]) + pit_pkg::DOT_W'(m01_ff[1])
                  + pit_pkg::DOT_W'(m01_ff[2]);
      dots_in.d02 = pit_pkg::DOT_W'(m02_ff[0]) + pit_pkg::DOT_W'(m02_ff[1])
                  + pit_pkg::DOT_W'(m02_ff[2]);
      dots_in.d11 = pit_pkg::DOT_W'(m11_ff[0]) + pit_pkg::DOT_W'(m11_ff[1])
                  + pit_pkg::DOT_W'(m11_ff[2]);
      dots_in.d12 = pit_pkg::DOT_W'(m12_ff[0]) + pit_pkg::DOT_W'(m12_ff[1])
                  + pit_pkg::DOT_W'(m12_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         dots_ff <= dots_in;
      end
   end

   assign dots = dots_ff;

endmodule

`default_nettype wire

>>> design/pit_wide_mul.sv
// ----------------------------------------------------------------------------
// pit_wide_mul
// Two-stage signed multiply of dot-product values: half-width partial
// products, then the shifted sum.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_wide_mul (
   input  wire logic                             clock,
   input  wire logic [1:0]                       en,
   input  wire logic signed [pit_pkg::DOT_W-1:0] a,
   input  wire logic signed [pit_pkg::DOT_W-1:0] b,
   output logic signed [pit_pkg::PROD_W-1:0]     p
);

   logic signed [pit_pkg::LO_W:0]   a_lo;
   logic signed [pit_pkg::LO_W:0]   b_lo;
   logic signed [pit_pkg::HI_W-1:0] a_hi;
   logic signed [pit_pkg::HI_W-1:0] b_hi;

   logic signed [pit_pkg::LL_W-1:0] ll_ff;
   logic signed [pit_pkg::LH_W-1:0] lh_ff;
   logic signed [pit_pkg::LH_W-1:0] hl_ff;
   logic signed [pit_pkg::HH_W-1:0] hh_ff;

   logic signed [pit_pkg::PROD_W-1:0] p_ff;
   logic signed [pit_pkg::PROD_W-1:0] p_in;

   assign a_lo = $signed({1'b0, a[pit_pkg::LO_W-1:0]});
   assign b_lo = $signed({1'b0, b[pit_pkg::LO_W-1:0]});
   assign a_hi = a[pit_pkg::DOT_W-1:pit_pkg::LO_W];
   assign b_hi = b[pit_pkg::DOT_W-1:pit_pkg::LO_W];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ll_ff <= a_lo * b_lo;
         lh_ff <= a_lo * b_hi;
         hl_ff <= a_hi * b_lo;
         hh_ff <= a_hi * b_hi;
      end
   end

   always_comb begin
      p_in = (pit_pkg::PROD_W'(hh_ff) <<< (2 * pit_pkg::LO_W))
           + ((pit_pkg::PROD_W'(lh_ff) + pit_pkg::PROD_W'(hl_ff)) <<< pit_pkg::LO_W)
           + pit_pkg::PROD_W'(ll_ff);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

>>> design/pit_decide.sv
// ----------------------------------------------------------------------------
// pit_decide
// Barycentric numerators and denominator, then the sign test into the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_decide (
   input  wire logic                  clock,
   input  wire logic [1:0]            en,
   input  wire pit_pkg::prod_set_type prods,
   output pit_pkg::result_type        result
);

   logic signed [pit_pkg::NUM_W-1:0]  den_ff;
   logic signed [pit_pkg::NUM_W-1:0]  nu_ff;
   logic signed [pit_pkg::NUM_W-1:0]  nv_ff;
   logic signed [pit_pkg::REST_W-1:0] rest;

   logic den_zero;
   logic den_neg;
   logic nu_pos;
   logic nu_neg;
   logic nv_pos;
   logic nv_neg;
   logic rest_pos;
   logic rest_neg;

   pit_pkg::result_type result_ff;
   pit_pkg::result_type result_in;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         den_ff <= pit_pkg::NUM_W'(prods.den_a) - pit_pkg::NUM_W'(prods.den_b);
         nu_ff  <= pit_pkg::NUM_W'(prods.nu_a)  - pit_pkg::NUM_W'(prods.nu_b);
         nv_ff  <= pit_pkg::NUM_W'(prods.nv_a)  - pit_pkg::NUM_W'(prods.nv_b);
      end
   end

   // u + v < 1  <=>  nu + nv - den has the opposite sign to den
   assign rest = pit_pkg::REST_W'(nu_ff) + pit_pkg::REST_W'(nv_ff)
               - pit_pkg::REST_W'(den_ff);

   assign den_zero = (den_ff == '0);
   assign den_neg  = den_ff[pit_pkg::NUM_W-1];
   assign nu_neg   = nu_ff[pit_pkg::NUM_W-1];
   assign nu_pos   = !nu_neg && (nu_ff != '0);
   assign nv_neg   = nv_ff[pit_pkg::NUM_W-1];
   assign nv_pos   = !nv_neg && (nv_ff != '0);
   assign rest_neg = rest[pit_pkg::REST_W-1];
   assign rest_pos = !rest_neg && (rest != '0);

   always_comb begin
      result_in.degenerate = den_zero;
      result_in.inside_res = !den_zero &&
         ((!den_neg && nu_pos && nv_pos && rest_neg) ||
          (den_neg && nu_neg && nv_neg && rest_pos));
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

>>> design/point_in_triangle_test_core.sv
// ----------------------------------------------------------------------------
// point_in_triangle_test_core
// Strict barycentric point-in-triangle test on a stream of 3-D items.
// ----------------------------------------------------------------------------
// req_*: one item per handshake, twelve signed 16-bit coordinates with 8
//   fraction bits (vertex 0, vertex 1, vertex 2, point; x, y, z each).
// rsp_*: one result item per input item, in order: inside_res, degenerate.
// Pipeline: the accepting edge loads the first of seven register stages
//   (edge vectors, component products, dot products, partial products,
//   wide products, numerators/denominator, result); rsp_tvalid is the
//   valid bit of the result stage.
// Throughput: one item per cycle while rsp_tready is high. Each stage has its
//   own valid bit, loads if empty or if the next stage loads; bubbles close up.
// Stall: while rsp_tready is low the result holds and the pipeline keeps
//   taking items until every stage is full; then req_tready drops.
// Reset: all valid bits clear; no result is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_triangle_test_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // vert0_x, vert0_y, vert0_z, vert1_x, vert1_y, vert1_z,
   // vert2_x, vert2_y, vert2_z, point_x, point_y, point_z (16 bits each)
   input  wire logic [pit_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // inside_res, degenerate, zero fill
   output logic [pit_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic [pit_pkg::NUM_STAGES-1:0] valid_ff;
   logic [pit_pkg::NUM_STAGES-1:0] valid_in;
   logic [pit_pkg::NUM_STAGES-1:0] en;

   pit_pkg::coord_set_type coords;
   pit_pkg::dot_set_type   dots;
   pit_pkg::prod_set_type  prods;
   pit_pkg::result_type    result;

   always_comb begin
      en[pit_pkg::NUM_STAGES-1] = !valid_ff[pit_pkg::NUM_STAGES-1] || rsp_tready;
      for (int i = pit_pkg::NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_comb begin
      valid_in[0] = en[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < pit_pkg::NUM_STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign coords = req_tdata[pit_pkg::NUM_COORDS*pit_pkg::COORD_W-1:0];

   pit_dot_unit u_dot (
      .clock  (clock),
      .en     (en[2:0]),
      .coords (coords),
      .dots   (dots)
   );

   pit_wide_mul u_mul_den_a (
      .clock (clock), .en (en[4:3]), .a (dots.d00), .b (dots.d11), .p (prods.den_a)
   );
   pit_wide_mul u_mul_den_b (
      .clock (clock), .en (en[4:3]), .a (dots.d01), .b (dots.d01), .p (prods.den_b)
   );
   pit_wide_mul u_mul_nu_a (
      .clock (clock), .en (en[4:3]), .a (dots.d11), .b (dots.d02), .p (prods.nu_a)
   );
   pit_wide_mul u_mul_nu_b (
      .clock (clock), .en (en[4:3]), .a (dots.d01), .b (dots.d12), .p (prods.nu_b)
   );
   pit_wide_mul u_mul_nv_a (
      .clock (clock), .en (en[4:3]), .a (dots.d00), .b (dots.d12), .p (prods.nv_a)
   );
   pit_wide_mul u_mul_nv_b (
      .clock (clock), .en (en[4:3]), .a (dots.d01), .b (dots.d02), .p (prods.nv_b)
   );

   pit_decide u_decide (
      .clock  (clock),
      .en     (en[6:5]),
      .prods  (prods),
      .result (result)
   );

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[pit_pkg::NUM_STAGES-1];
   assign rsp_tdata  = {{(pit_pkg::RSP_DATA_W-2){1'b0}}, result.degenerate,
                        result.inside_res};

`ifndef SYNTH
   a_degen_not_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("degenerate result flagged inside");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&valid_ff))
      else $error("input stalled with an empty stage");

   a_ready_follows_sink: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output drains");
`endif

endmodule

`default_nettype wire
